// ===== sv/lvsc_pkg.sv =====
// Package for the lane vector steering controller: payload and config types,
// sequencer steps, fixed constants, rounding and clamp helpers. No dependencies.
package lvsc_pkg;

	typedef struct packed {
		logic [6:0] x_start;
		logic [5:0] y_start;
		logic [6:0] x_end;
		logic [5:0] y_end;
		logic       frame_last;
		logic       frame_empty;
	} vec_t;

	typedef struct packed {
		logic signed [15:0] steer;
		logic signed [7:0]  wheel_l;
		logic signed [7:0]  wheel_r;
		logic [1:0]         drive_mode;
	} res_t;

	typedef enum logic [1:0] {
		MODE_BRAKE   = 2'd0,
		MODE_REVERSE = 2'd1,
		MODE_SLOWED  = 2'd2,
		MODE_NORMAL  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_PROP_GAIN      = 3'd0,
		REG_QUAD_GAIN      = 3'd1,
		REG_DERIV_GAIN     = 3'd2,
		REG_HEADING_WEIGHT = 3'd3,
		REG_LOOKAHEAD      = 3'd4,
		REG_MIN_SCALE      = 3'd5,
		REG_SMOOTH_ALPHA   = 3'd6,
		REG_INNER_SLOW     = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] prop_gain;
		logic [15:0] quad_gain;
		logic [15:0] deriv_gain;
		logic [15:0] heading_weight;
		logic [12:0] lookahead;
		logic [12:0] min_scale;
		logic [12:0] smooth_alpha;
		logic [12:0] inner_slow;
	} cfg_t;

	typedef enum logic [4:0] {
		S_HEAD, S_PROX, S_SCALE_A, S_SCALE_B, S_ERR_A, S_ERR_B, S_ERR_C,
		S_SQ, S_KP, S_KQ, S_KD, S_CMD, S_SMA, S_SMB,
		S_DFA, S_DFB, S_DFC, S_DFD, S_DFE, S_FIN
	} step_t;

	typedef struct packed {
		logic  take;
		logic  run;
		step_t step;
	} dp_cmd_t;

	typedef struct packed {
		logic found;
	} dp_stat_t;

	localparam int unsigned CENTER_COL    = 39;
	localparam int          HALF_TRACK_Q8 = 5760;
	localparam int unsigned ONE_Q12       = 4096;
	localparam longint      ERR_MAX       = 524287;
	localparam longint      CMD_MAX       = 25600;
	localparam int          REVERSE_SPEED = -85;
	localparam int unsigned IMG_BOTTOM    = 51;
	localparam int unsigned FULL_SCALE    = 104857600;
	localparam int unsigned RECIP_100     = 20972;
	localparam int unsigned PROX_SHIFT    = 26;

	// Round half away from zero, then shift right.
	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
		input logic [5:0] sh);
		logic signed [63:0] half;
		half = 64'sd1 <<< (sh - 6'd1);
		if (v >= 0)
			rnd_shift = (v + half) >>> sh;
		else
			rnd_shift = -(((-v) + half) >>> sh);
	endfunction

	function automatic logic signed [63:0] sat_sym(input logic signed [63:0] v,
		input longint lim);
		if (v > lim)
			sat_sym = lim;
		else if (v < -lim)
			sat_sym = -lim;
		else
			sat_sym = v;
	endfunction

	function automatic logic [12:0] q12(input logic [12:0] v);
		q12 = (v > 13'(ONE_Q12)) ? 13'(ONE_Q12) : v;
	endfunction

endpackage

// ===== sv/lvsc_ctrl.sv =====
// Controller of the lane vector steering controller: handshake and step
// sequencing of the frame-end math. Depends on lvsc_pkg.
module lvsc_ctrl
	import lvsc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     vec_valid,
	input  vec_t     vec,
	output logic     vec_stall,
	output logic     res_valid,
	input  logic     res_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	state_t state_q;
	step_t  step_q;
	step_t  step_next;

	assign vec_stall = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_OUT);
	assign cmd.take  = (state_q == ST_IDLE) && vec_valid;
	assign cmd.run   = (state_q == ST_CALC);
	assign cmd.step  = step_q;

	always_comb begin
		unique case (step_q)
			S_HEAD:    step_next = stat.found ? S_PROX : S_SQ;
			S_PROX:    step_next = S_SCALE_A;
			S_SCALE_A: step_next = S_SCALE_B;
			S_SCALE_B: step_next = S_ERR_A;
			S_ERR_A:   step_next = S_ERR_B;
			S_ERR_B:   step_next = S_ERR_C;
			S_ERR_C:   step_next = S_SQ;
			S_SQ:      step_next = S_KP;
			S_KP:      step_next = S_KQ;
			S_KQ:      step_next = S_KD;
			S_KD:      step_next = S_CMD;
			S_CMD:     step_next = S_SMA;
			S_SMA:     step_next = S_SMB;
			S_SMB:     step_next = S_DFA;
			S_DFA:     step_next = S_DFB;
			S_DFB:     step_next = S_DFC;
			S_DFC:     step_next = S_DFD;
			S_DFD:     step_next = S_DFE;
			S_DFE:     step_next = S_FIN;
			S_FIN:     step_next = S_HEAD;
			default:   step_next = S_HEAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= S_HEAD;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (vec_valid && (vec.frame_last || vec.frame_empty)) begin
						state_q <= ST_CALC;
						step_q  <= S_HEAD;
					end
				end
				ST_CALC: begin
					step_q <= step_next;
					if (step_q == S_FIN)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!res_stall)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/lvsc_datapath.sv =====
// Datapath of the lane vector steering controller: vector selection, frame
// state and one shared registered multiplier stepped by lvsc_ctrl. Uses lvsc_pkg.
module lvsc_datapath
	import lvsc_pkg::*;
#(
	parameter int MIN_VERT_SPAN    = 5,
	parameter int MIN_BOTTOM_ROW   = 20,
	parameter int LEFT_BASE_SPEED  = 50,
	parameter int RIGHT_BASE_SPEED = 50,
	parameter int LOST_LIMIT       = 5
) (
	input  logic     clk,
	input  logic     arst_n,
	input  vec_t     vec,
	input  cfg_t     cfg,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	output res_t     res
);

	localparam longint unsigned DIV_K   = longint'(IMG_BOTTOM) - longint'(MIN_BOTTOM_ROW);
	localparam longint unsigned RECIP_K = ((64'd1 << PROX_SHIFT) + DIV_K - 1) / DIV_K;

	// frame state
	logic [7:0] lgap_q, rgap_q;
	logic [6:0] lbx_q, ltx_q, rbx_q, rtx_q;
	logic [5:0] lby_q, rby_q;
	logic [1:0] side_q;
	logic [3:0] lost_q;
	logic       seen_q, empty_q;
	logic signed [19:0] prev_q, held_q, e_q;
	logic signed [15:0] sm_q, cmd_q;

	// step temporaries
	logic signed [59:0] prod_q;
	logic signed [19:0] cte_q;
	logic [12:0]        prox_q, scale_q;
	logic signed [21:0] s_q;
	logic signed [30:0] t_q;
	logic signed [49:0] acc_q;
	logic [26:0]        diff_q;
	logic [13:0]        x_q;
	res_t               res_q;

	logic [12:0] la, ms, al, df;
	assign la = q12(cfg.lookahead);
	assign ms = q12(cfg.min_scale);
	assign al = q12(cfg.smooth_alpha);
	assign df = q12(cfg.inner_slow);

	assign stat.found = !empty_q && (side_q != 2'b00);
	assign res = res_q;

	// vector intake
	logic [5:0] span, by;
	logic [6:0] bx, tx;
	logic [7:0] gap;
	logic       keep, is_left;

	always_comb begin
		span    = (vec.y_end > vec.y_start) ? (vec.y_end - vec.y_start)
			: (vec.y_start - vec.y_end);
		if (vec.y_start > vec.y_end) begin
			bx = vec.x_start; by = vec.y_start; tx = vec.x_end;
		end else begin
			bx = vec.x_end; by = vec.y_end; tx = vec.x_start;
		end
		is_left = bx < 7'(CENTER_COL);
		gap     = is_left ? 8'(7'(CENTER_COL) - bx) : 8'(bx - 7'(CENTER_COL));
		keep    = (span >= 6'(MIN_VERT_SPAN)) && (by >= 6'(MIN_BOTTOM_ROW));
	end

	// lane centre geometry, Q8.8
	logic signed [17:0] cbot, ctop, cby, heading, dy;
	logic [7:0] sbx, stx;
	logic [6:0] sby;
	logic [18:0] nprox;

	always_comb begin
		sbx = {1'b0, lbx_q} + {1'b0, rbx_q};
		stx = {1'b0, ltx_q} + {1'b0, rtx_q};
		sby = {1'b0, lby_q} + {1'b0, rby_q};
		case (side_q)
			2'b11: begin
				cbot = $signed({3'b0, sbx, 7'b0});
				ctop = $signed({3'b0, stx, 7'b0});
				cby  = $signed({4'b0, sby, 7'b0});
			end
			2'b01: begin
				cbot = $signed({3'b0, lbx_q, 8'b0}) + 18'(HALF_TRACK_Q8);
				ctop = $signed({3'b0, ltx_q, 8'b0}) + 18'(HALF_TRACK_Q8);
				cby  = $signed({4'b0, lby_q, 8'b0});
			end
			default: begin
				cbot = $signed({3'b0, rbx_q, 8'b0}) - 18'(HALF_TRACK_Q8);
				ctop = $signed({3'b0, rtx_q, 8'b0}) - 18'(HALF_TRACK_Q8);
				cby  = $signed({4'b0, rby_q, 8'b0});
			end
		endcase
		heading = ctop - cbot;
		dy      = cby - 18'(MIN_BOTTOM_ROW * 256);
		nprox   = (dy < 0) ? 19'd0 : {1'b0, dy[13:0], 4'b0};
	end

	// shared multiplier operand select
	logic signed [31:0] opa;
	logic signed [27:0] opb;
	logic [19:0]        abs_e;
	logic [14:0]        abs_sm;
	logic signed [20:0] ediff;
	logic signed [16:0] smd;

	always_comb begin
		abs_e  = (e_q < 0) ? 20'(-e_q) : 20'(e_q);
		abs_sm = (sm_q < 0) ? 15'(-sm_q) : 15'(sm_q);
		ediff  = 21'(e_q) - 21'(prev_q);
		smd    = 17'(sm_q) - 17'(cmd_q);
		opa    = '0;
		opb    = '0;
		case (cmd.step)
			S_HEAD: begin
				opa = 32'(heading); opb = $signed({15'b0, la});
			end
			S_PROX: begin
				opa = $signed({13'b0, nprox}); opb = 28'(RECIP_K);
			end
			S_SCALE_A: begin
				opa = $signed({16'b0, cfg.heading_weight}); opb = 28'(heading);
			end
			S_SCALE_B: begin
				opa = $signed({19'b0, 13'(13'(ONE_Q12) - ms)});
				opb = $signed({15'b0, prox_q});
			end
			S_ERR_B: begin
				opa = 32'(s_q); opb = $signed({15'b0, scale_q});
			end
			S_SQ: begin
				opa = 32'(e_q); opb = $signed({8'b0, abs_e});
			end
			S_KP: begin
				opa = 32'(e_q); opb = $signed({12'b0, cfg.prop_gain});
			end
			S_KQ: begin
				opa = 32'(t_q); opb = $signed({12'b0, cfg.quad_gain});
			end
			S_KD: begin
				opa = 32'(ediff); opb = $signed({12'b0, cfg.deriv_gain});
			end
			S_SMA: begin
				opa = 32'(smd); opb = $signed({15'b0, al});
			end
			S_DFA: begin
				opa = $signed({17'b0, abs_sm}); opb = $signed({15'b0, df});
			end
			S_DFC: begin
				opa = $signed({5'b0, diff_q});
				opb = (sm_q > 0) ? 28'(RIGHT_BASE_SPEED) : 28'(LEFT_BASE_SPEED);
			end
			S_DFE: begin
				opa = $signed({18'b0, x_q}); opb = 28'(RECIP_100);
			end
			default: begin
				opa = '0; opb = '0;
			end
		endcase
	end

	always_ff @(posedge clk)
		prod_q <= opa * opb;

	// product consumers
	logic [21:0]        proxq;
	logic [6:0]         spdq;
	logic signed [63:0] acc_sum;

	assign proxq   = prod_q[47:26];
	assign spdq    = prod_q[27:21];
	assign acc_sum = 64'(acc_q) + 64'(prod_q);

	always_ff @(posedge clk) begin
		if (cmd.run) begin
			case (cmd.step)
				S_PROX: cte_q <= 20'(rnd_shift((64'(cbot) <<< 12) + 64'(prod_q), 6'd12)
					- 64'sd9984);
				S_SCALE_A: prox_q <= (proxq > 22'(ONE_Q12)) ? 13'(ONE_Q12) : proxq[12:0];
				S_SCALE_B: s_q <= 22'(rnd_shift((64'(cte_q) <<< 12) + 64'(prod_q), 6'd12));
				S_ERR_A: scale_q <= ms + 13'((prod_q + 60'sd2048) >>> 12);
				S_KP: t_q <= 31'(rnd_shift(64'(prod_q), 6'd8));
				S_KQ: acc_q <= 50'(prod_q);
				S_KD: acc_q <= 50'(acc_sum);
				S_CMD: cmd_q <= 16'(sat_sym(rnd_shift(acc_sum, 6'd12), CMD_MAX));
				S_DFB: diff_q <= 27'(60'(FULL_SCALE) - prod_q);
				S_DFD: x_q <= prod_q[33:20];
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.run && cmd.step == S_FIN) begin
			if (!seen_q) begin
				res_q.steer      <= '0;
				res_q.wheel_l    <= '0;
				res_q.wheel_r    <= '0;
				res_q.drive_mode <= MODE_BRAKE;
			end else if (lost_q > 4'(LOST_LIMIT)) begin
				res_q.steer      <= sm_q;
				res_q.wheel_l    <= 8'(REVERSE_SPEED);
				res_q.wheel_r    <= 8'(REVERSE_SPEED);
				res_q.drive_mode <= MODE_REVERSE;
			end else if (lost_q != 4'd0) begin
				res_q.steer      <= sm_q;
				res_q.wheel_l    <= 8'(LEFT_BASE_SPEED / 2);
				res_q.wheel_r    <= 8'(RIGHT_BASE_SPEED / 2);
				res_q.drive_mode <= MODE_SLOWED;
			end else begin
				res_q.steer      <= sm_q;
				res_q.wheel_l    <= (sm_q < 0) ? {1'b0, spdq} : 8'(LEFT_BASE_SPEED);
				res_q.wheel_r    <= (sm_q > 0) ? {1'b0, spdq} : 8'(RIGHT_BASE_SPEED);
				res_q.drive_mode <= MODE_NORMAL;
			end
		end
	end

	// frame and control-law state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lgap_q  <= 8'hFF;
			rgap_q  <= 8'hFF;
			lbx_q   <= '0; ltx_q <= '0; lby_q <= '0;
			rbx_q   <= '0; rtx_q <= '0; rby_q <= '0;
			side_q  <= '0;
			lost_q  <= '0;
			seen_q  <= 1'b0;
			empty_q <= 1'b0;
			prev_q  <= '0;
			held_q  <= '0;
			e_q     <= '0;
			sm_q    <= '0;
		end else if (cmd.take) begin
			empty_q <= vec.frame_empty;
			if (!vec.frame_empty) begin
				seen_q <= 1'b1;
				if (keep && is_left && gap < lgap_q) begin
					lgap_q <= gap; lbx_q <= bx; lby_q <= by; ltx_q <= tx;
					side_q[0] <= 1'b1;
				end
				if (keep && !is_left && gap < rgap_q) begin
					rgap_q <= gap; rbx_q <= bx; rby_q <= by; rtx_q <= tx;
					side_q[1] <= 1'b1;
				end
			end
		end else if (cmd.run) begin
			case (cmd.step)
				S_HEAD: begin
					if (stat.found) begin
						lost_q <= '0;
					end else begin
						e_q <= held_q;
						if (lost_q != 4'hF)
							lost_q <= lost_q + 4'd1;
					end
				end
				S_ERR_C: begin
					e_q    <= 20'(sat_sym(rnd_shift(64'(prod_q), 6'd12), ERR_MAX));
					held_q <= 20'(sat_sym(rnd_shift(64'(prod_q), 6'd12), ERR_MAX));
				end
				S_CMD: prev_q <= e_q;
				S_SMB: sm_q <= seen_q ? 16'(sat_sym(rnd_shift((64'(cmd_q) <<< 12)
					+ 64'(prod_q), 6'd12), CMD_MAX)) : 16'sd0;
				S_FIN: begin
					lgap_q <= 8'hFF;
					rgap_q <= 8'hFF;
					side_q <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/lane_vector_steering_controller_top.sv =====
// Top level of the lane vector steering controller: APB register file,
// controller and datapath. Depends on lvsc_pkg, lvsc_ctrl, lvsc_datapath.
//
// Usage: line vectors of one camera frame enter on the vec channel
// (vec_valid / vec_stall), one transaction per vector; the last vector of a
// frame carries frame_last, and a frame with no vectors is one transaction
// with frame_empty set. A vector that does not end a frame is taken whenever
// the block is idle, and the next can follow at once. A frame-ending
// transaction starts the frame-end sequence on one shared multiplier, with
// the full step chain when a lane was kept and one that skips from S_HEAD
// straight to S_SQ when the frame is lost or empty; then the result sits in
// an output register on the res channel. vec_stall stays high from a frame
// end until its result transaction is taken; while res_stall is high the
// result is held unchanged. Gains and blend factors are written over the
// APB port (4 bytes per register, pready always high); the user must write
// them only while the block is idle, which the block itself does not enforce.
// Reset clears the lane memory, the error history, the smoothing state and
// loads the register defaults; the first result after reset brakes until
// a vector has been seen.
module lane_vector_steering_controller_top
	import lvsc_pkg::*;
#(
	parameter int MIN_VERT_SPAN    = 5,
	parameter int MIN_BOTTOM_ROW   = 20,
	parameter int LEFT_BASE_SPEED  = 50,
	parameter int RIGHT_BASE_SPEED = 50,
	parameter int LOST_LIMIT       = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        vec_valid,
	output logic        vec_stall,
	input  vec_t        vec,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t     cfg_q;
	dp_cmd_t  cmd;
	dp_stat_t stat;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[4:2]);

	// Register writes land at the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain      <= 16'd4096;
			cfg_q.quad_gain      <= 16'd0;
			cfg_q.deriv_gain     <= 16'd0;
			cfg_q.heading_weight <= 16'd4096;
			cfg_q.lookahead      <= 13'd2048;
			cfg_q.min_scale      <= 13'd2048;
			cfg_q.smooth_alpha   <= 13'd0;
			cfg_q.inner_slow     <= 13'd2048;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_PROP_GAIN:      cfg_q.prop_gain      <= pwdata[15:0];
				REG_QUAD_GAIN:      cfg_q.quad_gain      <= pwdata[15:0];
				REG_DERIV_GAIN:     cfg_q.deriv_gain     <= pwdata[15:0];
				REG_HEADING_WEIGHT: cfg_q.heading_weight <= pwdata[15:0];
				REG_LOOKAHEAD:      cfg_q.lookahead      <= pwdata[12:0];
				REG_MIN_SCALE:      cfg_q.min_scale      <= pwdata[12:0];
				REG_SMOOTH_ALPHA:   cfg_q.smooth_alpha   <= pwdata[12:0];
				REG_INNER_SLOW:     cfg_q.inner_slow     <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	// Read back the stored register, zero extended.
	always_comb begin
		unique case (idx)
			REG_PROP_GAIN:      prdata = {16'b0, cfg_q.prop_gain};
			REG_QUAD_GAIN:      prdata = {16'b0, cfg_q.quad_gain};
			REG_DERIV_GAIN:     prdata = {16'b0, cfg_q.deriv_gain};
			REG_HEADING_WEIGHT: prdata = {16'b0, cfg_q.heading_weight};
			REG_LOOKAHEAD:      prdata = {19'b0, cfg_q.lookahead};
			REG_MIN_SCALE:      prdata = {19'b0, cfg_q.min_scale};
			REG_SMOOTH_ALPHA:   prdata = {19'b0, cfg_q.smooth_alpha};
			REG_INNER_SLOW:     prdata = {19'b0, cfg_q.inner_slow};
			default:            prdata = '0;
		endcase
	end

	// Sequence handshakes and frame-end steps.
	lvsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.vec_valid (vec_valid),
		.vec       (vec),
		.vec_stall (vec_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Hold lane state, run the steering math, hold the result.
	lvsc_datapath #(
		.MIN_VERT_SPAN    (MIN_VERT_SPAN),
		.MIN_BOTTOM_ROW   (MIN_BOTTOM_ROW),
		.LEFT_BASE_SPEED  (LEFT_BASE_SPEED),
		.RIGHT_BASE_SPEED (RIGHT_BASE_SPEED),
		.LOST_LIMIT       (LOST_LIMIT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.vec    (vec),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.stat   (stat),
		.res    (res)
	);

endmodule

// ===== sv/lvsc_checker.sv =====
// Port-level checker for the lane vector steering controller, bound to the
// top level. Depends on lvsc_pkg.
module lvsc_checker
	import lvsc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic vec_stall,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> vec_stall)
		else $error("vector taken while a result waits");

	a_brake_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.drive_mode == MODE_BRAKE |->
		res.steer == 16'sd0 && res.wheel_l == 8'sd0 && res.wheel_r == 8'sd0)
		else $error("brake result not zero");

	a_reverse: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.drive_mode == MODE_REVERSE |->
		res.wheel_l == -8'sd85 && res.wheel_r == -8'sd85)
		else $error("reverse speeds wrong");

	a_steer_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.steer <= 16'sd25600 && res.steer >= -16'sd25600)
		else $error("steer out of range");

endmodule

bind lane_vector_steering_controller_top lvsc_checker u_lvsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.vec_stall (vec_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

// ===== tb/sv/lane_vector_steering_controller_top_test.sv =====
// Self-checking testbench for the lane vector steering controller top level.
// Depends on lvsc_pkg and lane_vector_steering_controller_top; drives frames of
// line vectors, predicts each frame-end result in a local model and compares.
module lane_vector_steering_controller_top_test;
	import lvsc_pkg::*;

	localparam int MIN_SPAN = 5;
	localparam int MIN_ROW = 20;
	localparam int BASE_L = 50;
	localparam int BASE_R = 50;
	localparam int LOST_LIM = 5;
	localparam longint CYCLE_LIMIT = 1500000;

	logic        clk;
	logic        arst_n;
	logic        vec_valid;
	logic        vec_stall;
	vec_t        vec;
	logic        res_valid;
	logic        res_stall;
	res_t        res;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lane_vector_steering_controller_top DUT (
		.clk(clk), .arst_n(arst_n),
		.vec_valid(vec_valid), .vec_stall(vec_stall), .vec(vec),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predictor state: register copy and lane memory.
	longint g_prop, g_quad, g_deriv, g_head, g_look, g_mins, g_alpha, g_slow;
	longint gap_l, gap_r, lbx, ltx, lby, rbx, rtx, rby, lost_cnt;
	logic [1:0] sides;
	bit     seen_line;
	longint err_prev, err_held, steer_sm;

	res_t   steer_expected[$];
	int     fail_count;
	longint cycles;
	bit     quiet_tail;     // no idling in the last part of the run
	int     hold_res;       // long receiver hold-off, in cycles

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic longint round_sh(longint v, int s);
		longint half;
		half = longint'(1) << (s - 1);
		if (v >= 0)
			return (v + half) >>> s;
		return -(((-v) + half) >>> s);
	endfunction

	function automatic longint clamp_sym(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic longint frac12(longint v);
		return (v > 4096) ? 4096 : v;
	endfunction

	task automatic lane_reset();
		g_prop = 4096; g_quad = 0; g_deriv = 0; g_head = 4096;
		g_look = 2048; g_mins = 2048; g_alpha = 0; g_slow = 2048;
		gap_l = 255; gap_r = 255; sides = 2'b00;
		lbx = 0; ltx = 0; lby = 0; rbx = 0; rtx = 0; rby = 0;
		lost_cnt = 0; seen_line = 0;
		err_prev = 0; err_held = 0; steer_sm = 0;
	endtask

	task automatic lane_config(reg_idx_t idx, logic [31:0] v);
		case (idx)
			REG_PROP_GAIN:      g_prop = v[15:0];
			REG_QUAD_GAIN:      g_quad = v[15:0];
			REG_DERIV_GAIN:     g_deriv = v[15:0];
			REG_HEADING_WEIGHT: g_head = v[15:0];
			REG_LOOKAHEAD:      g_look = v[12:0];
			REG_MIN_SCALE:      g_mins = v[12:0];
			REG_SMOOTH_ALPHA:   g_alpha = v[12:0];
			REG_INNER_SLOW:     g_slow = v[12:0];
		endcase
	endtask

	function automatic longint lane_error();
		longint cbot, ctop, cby, tgt, cte, hd, prox, scl, s, e, la, ms;
		la = frac12(g_look);
		ms = frac12(g_mins);
		if (sides == 2'b11) begin
			cbot = (lbx + rbx) << 7;
			ctop = (ltx + rtx) << 7;
			cby = (lby + rby) << 7;
		end else if (sides == 2'b01) begin
			cbot = (lbx << 8) + 5760;
			ctop = (ltx << 8) + 5760;
			cby = lby << 8;
		end else begin
			cbot = (rbx << 8) - 5760;
			ctop = (rtx << 8) - 5760;
			cby = rby << 8;
		end
		tgt = round_sh(cbot * (4096 - la) + ctop * la, 12);
		cte = tgt - 39 * 256;
		hd = ctop - cbot;
		prox = ((cby - MIN_ROW * 256) * 4096) / ((51 - MIN_ROW) * 256);
		if (prox < 0)
			prox = 0;
		if (prox > 4096)
			prox = 4096;
		scl = ms + round_sh((4096 - ms) * prox, 12);
		s = round_sh(cte * 4096 + g_head * hd, 12);
		e = round_sh(scl * s, 12);
		return clamp_sym(e, 524287);
	endfunction

	function automatic res_t lane_frame_end(bit found);
		longint e, ae, cmd, a, st, sl, sr, full;
		res_t r;
		mode_t m;
		st = 0; sl = 0; sr = 0;
		if (found) begin
			e = lane_error();
			err_held = e;
			lost_cnt = 0;
		end else begin
			e = err_held;
			if (lost_cnt < 15)
				lost_cnt++;
		end
		gap_l = 255; gap_r = 255; sides = 2'b00;
		ae = (e < 0) ? -e : e;
		cmd = g_prop * e + g_quad * round_sh(e * ae, 8) + g_deriv * (e - err_prev);
		cmd = clamp_sym(round_sh(cmd, 12), 25600);
		err_prev = e;
		a = frac12(g_alpha);
		steer_sm = clamp_sym(round_sh(a * steer_sm + (4096 - a) * cmd, 12), 25600);
		if (!seen_line) begin
			steer_sm = 0;
			m = MODE_BRAKE;
		end else if (lost_cnt > LOST_LIM) begin
			st = steer_sm; sl = -85; sr = -85;
			m = MODE_REVERSE;
		end else if (lost_cnt > 0) begin
			st = steer_sm; sl = BASE_L / 2; sr = BASE_R / 2;
			m = MODE_SLOWED;
		end else begin
			full = 25600 * 4096;
			st = steer_sm; sl = BASE_L; sr = BASE_R;
			if (st > 0)
				sr = (BASE_R * (full - st * frac12(g_slow))) / full;
			else if (st < 0)
				sl = (BASE_L * (full + st * frac12(g_slow))) / full;
			m = MODE_NORMAL;
		end
		r.steer = st[15:0];
		r.wheel_l = sl[7:0];
		r.wheel_r = sr[7:0];
		r.drive_mode = m;
		return r;
	endfunction

	// Returns 1 when the item closes a frame, with the predicted result.
	function automatic bit lane_step(vec_t v, output res_t r);
		longint span, bx, by, tx, gap;
		r = '0;
		if (v.frame_empty) begin
			r = lane_frame_end(0);
			return 1;
		end
		seen_line = 1;
		span = (v.y_end > v.y_start) ? v.y_end - v.y_start : v.y_start - v.y_end;
		if (span >= MIN_SPAN) begin
			if (v.y_start > v.y_end) begin
				bx = v.x_start; by = v.y_start; tx = v.x_end;
			end else begin
				bx = v.x_end; by = v.y_end; tx = v.x_start;
			end
			if (by >= MIN_ROW) begin
				if (bx < 39) begin
					gap = 39 - bx;
					if (gap < gap_l) begin
						gap_l = gap; lbx = bx; lby = by; ltx = tx;
						sides[0] = 1'b1;
					end
				end else begin
					gap = bx - 39;
					if (gap < gap_r) begin
						gap_r = gap; rbx = bx; rby = by; rtx = tx;
						sides[1] = 1'b1;
					end
				end
			end
		end
		if (v.frame_last) begin
			r = lane_frame_end(sides != 2'b00);
			return 1;
		end
		return 0;
	endfunction

	// Accept results; compare field by field with the oldest expectation.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (steer_expected.size() == 0) begin
				$error("result with none expected: %h", res);
				fail_count++;
			end else begin
				want = steer_expected.pop_front();
				if (res.steer !== want.steer) begin
					$error("steer: expected %0d got %0d", want.steer, res.steer);
					fail_count++;
				end
				if (res.wheel_l !== want.wheel_l) begin
					$error("wheel_l: expected %0d got %0d", want.wheel_l,
						res.wheel_l);
					fail_count++;
				end
				if (res.wheel_r !== want.wheel_r) begin
					$error("wheel_r: expected %0d got %0d", want.wheel_r,
						res.wheel_r);
					fail_count++;
				end
				if (res.drive_mode !== want.drive_mode) begin
					$error("drive_mode: expected %0d got %0d", want.drive_mode,
						res.drive_mode);
					fail_count++;
				end
			end
		end
	end

	// Receiver: random stall bursts, a long hold-off on request, none at the end.
	initial begin
		int n;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_res > 0) begin
				res_stall <= 1'b1;
				hold_res--;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 14);
				res_stall <= 1'b1;
				repeat (n - 1) @(posedge clk);
			end else begin
				res_stall <= 1'b0;
				if (!quiet_tail && $urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// Offer one transaction and hold it until taken; the predictor runs on accept.
	task automatic send_item(vec_t v, bit check_fixed, res_t fixed);
		res_t r;
		if (!quiet_tail && $urandom_range(0, 6) == 0) begin
			vec_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		vec_valid <= 1'b1;
		vec <= v;
		do
			@(posedge clk);
		while (vec_stall);
		if (lane_step(v, r)) begin
			if (check_fixed && r !== fixed) begin
				$error("directed row: predictor gives %h, table says %h", r, fixed);
				fail_count++;
			end
			steer_expected.push_back(r);
		end
	endtask

	// Wait for every expected result, then let a frame end in flight settle.
	task automatic drain();
		vec_valid <= 1'b0;
		while (steer_expected.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic reg_write(reg_idx_t idx, logic [31:0] v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 5'(idx) << 2; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		lane_config(idx, v);
		@(posedge clk);
	endtask

	function automatic vec_t mk(int xs, int ys, int xe, int ye, bit last, bit empty);
		vec_t v;
		v.x_start = 7'(xs); v.y_start = 6'(ys);
		v.x_end = 7'(xe); v.y_end = 6'(ye);
		v.frame_last = last; v.frame_empty = empty;
		return v;
	endfunction

	// A plausible lane vector on one side, with a one-in-eight chance of junk.
	function automatic vec_t lane_vec(bit last);
		int bx, by, tx, ty;
		if ($urandom_range(0, 7) == 0)
			return mk($urandom_range(0, 127), $urandom_range(0, 63),
				$urandom_range(0, 127), $urandom_range(0, 63), last, 0);
		bx = $urandom_range(0, 1) ? $urandom_range(0, 38) : $urandom_range(39, 127);
		by = $urandom_range(20, 63);
		ty = $urandom_range(0, by - 5);
		tx = $urandom_range(0, 127);
		if ($urandom_range(0, 1))
			return mk(bx, by, tx, ty, last, 0);
		return mk(tx, ty, bx, by, last, 0);
	endfunction

	typedef struct {
		vec_t v;
		bit   fixed;
		res_t r;
	} row_t;

	initial begin
		row_t rows[$];
		row_t rw;
		res_t none;
		int sent, nvec, k, phase;
		reg_idx_t idx;

		vec_valid = 1'b0; vec = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		arst_n = 1'b0;
		cycles = 0; fail_count = 0; quiet_tail = 0; hold_res = 0;
		none = '0;
		lane_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: fixed rows are the brake-at-reset cases.
		rows.push_back('{mk(0, 0, 0, 0, 1, 1), 1, '{0, 0, 0, MODE_BRAKE}});
		rows.push_back('{mk(127, 63, 127, 63, 1, 1), 1, '{0, 0, 0, MODE_BRAKE}});
		rows.push_back('{mk(30, 40, 32, 10, 0, 0), 0, none});
		rows.push_back('{mk(50, 10, 48, 50, 1, 0), 0, none});
		rows.push_back('{mk(10, 30, 10, 33, 1, 0), 0, none});     // short span, lost
		rows.push_back('{mk(10, 5, 12, 15, 1, 0), 0, none});      // bottom too high
		rows.push_back('{mk(20, 30, 60, 30, 1, 0), 0, none});     // equal rows
		rows.push_back('{mk(0, 0, 0, 63, 0, 0), 0, none});
		rows.push_back('{mk(127, 63, 127, 0, 1, 0), 0, none});
		rows.push_back('{mk(30, 40, 35, 10, 0, 0), 0, none});     // equal gaps on both sides
		rows.push_back('{mk(48, 40, 0, 10, 0, 0), 0, none});
		rows.push_back('{mk(30, 10, 20, 40, 1, 0), 0, none});
		rows.push_back('{mk(38, 63, 0, 0, 0, 0), 0, none});
		rows.push_back('{mk(39, 63, 127, 0, 0, 0), 0, none});
		rows.push_back('{mk(0, 0, 0, 0, 0, 1), 0, none});         // empty inside a frame
		for (k = 0; k < 7; k++)
			rows.push_back('{mk(0, 0, 0, 0, 1, 1), 0, none});     // into reverse search
		rows.push_back('{mk(127, 20, 0, 63, 1, 0), 0, none});
		foreach (rows[i]) begin
			rw = rows[i];
			send_item(rw.v, rw.fixed, rw.r);
		end
		drain();

		// Random phases: each opens with a register set-up while idle.
		sent = 0;
		phase = 0;
		while (sent < 1920) begin
			if (phase == 0) begin
				reg_write(REG_PROP_GAIN, 32'd65535);
				reg_write(REG_QUAD_GAIN, 32'd65535);
				reg_write(REG_DERIV_GAIN, 32'd65535);
				reg_write(REG_HEADING_WEIGHT, 32'd65535);
				reg_write(REG_LOOKAHEAD, 32'd8191);
				reg_write(REG_MIN_SCALE, 32'd8191);
				reg_write(REG_SMOOTH_ALPHA, 32'd8191);
				reg_write(REG_INNER_SLOW, 32'd8191);
			end else if (phase == 1) begin
				for (k = 0; k < 8; k++)
					reg_write(reg_idx_t'(k), 32'd0);
			end else if (phase == 2) begin
				reg_write(REG_PROP_GAIN, 32'd4096);
				reg_write(REG_SMOOTH_ALPHA, 32'd4096);
				reg_write(REG_LOOKAHEAD, 32'd4096);
				reg_write(REG_MIN_SCALE, 32'd4096);
				reg_write(REG_INNER_SLOW, 32'd4096);
			end else begin
				for (k = 0; k < 8; k++) begin
					idx = reg_idx_t'(k);
					if (k < 4)
						reg_write(idx, $urandom_range(0, 3) == 0 ?
							$urandom_range(0, 65535) : $urandom_range(0, 12000));
					else
						reg_write(idx, $urandom_range(0, 8191));
				end
			end
			if (phase == 4)
				hold_res = 400;     // receiver holds off; the block backs up
			for (k = 0; k < 40 && sent < 1920; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					send_item(mk($urandom_range(0, 127), $urandom_range(0, 63),
						$urandom_range(0, 127), $urandom_range(0, 63),
						$urandom_range(0, 1), 1), 0, none);
					sent++;
				end else begin
					nvec = $urandom_range(1, 10);
					while (nvec > 0) begin
						send_item(lane_vec(nvec == 1), 0, none);
						nvec--;
						sent++;
					end
				end
			end
			if (sent >= 1700)
				quiet_tail = 1;
			// Sender pauses until every result has come, then reconfigures.
			drain();
			phase++;
		end

		drain();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
